// ===== rtl/smtp_pkg.sv =====
// Shared types, codes and helpers for the SMTP reply parser.
package smtp_pkg;

  localparam int unsigned LineLenBitsDef = 10;
  localparam int unsigned CfgLenBits     = 10;
  localparam logic [CfgLenBits-1:0] MaxLineLenRst = 10'd512;

  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChDash  = 8'h2d;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // reply status
  localparam logic [2:0] StDone      = 3'd0;
  localparam logic [2:0] StTooLong   = 3'd1;
  localparam logic [2:0] StShort     = 3'd2;
  localparam logic [2:0] StBadDigit  = 3'd3;
  localparam logic [2:0] StBadSep    = 3'd4;
  localparam logic [2:0] StCodeChg   = 3'd5;
  localparam logic [2:0] StStreamEnd = 3'd6;

  // reply class
  localparam logic [1:0] ClsOk    = 2'd0;
  localparam logic [1:0] ClsTemp  = 2'd1;
  localparam logic [1:0] ClsPerm  = 2'd2;
  localparam logic [1:0] ClsOther = 2'd3;

  // separator seen at position 3
  localparam logic [1:0] SepNone  = 2'd0;
  localparam logic [1:0] SepSpace = 2'd1;
  localparam logic [1:0] SepDash  = 2'd2;
  localparam logic [1:0] SepOther = 2'd3;

  typedef struct packed {
    logic       emit;
    logic [9:0] code;
    logic [1:0] cls;
    logic [2:0] status;
  } result_t;

  function automatic logic [1:0] class_of(input logic [9:0] code);
    logic [1:0] c;
    if (code >= 10'd200 && code < 10'd400) c = ClsOk;
    else if (code >= 10'd400 && code < 10'd500) c = ClsTemp;
    else if (code >= 10'd500 && code < 10'd600) c = ClsPerm;
    else c = ClsOther;
    return c;
  endfunction

endpackage

// ===== rtl/smtp_reply_parser_core.sv =====
// Top level of the SMTP reply parser: stream ports, input/result registers.
// A byte is taken into the input register and checked from there; if it ends
// a reply, its result is loaded into the result register for the master side.
// Throughput: one byte per cycle unless a byte that ends a reply meets a held
// result; the input register refills and no-result bytes pass while one waits.
// Reset (rst_ni low, async): both stages empty, line/reply state cleared,
// max_line_len back to 512.
module smtp_reply_parser_core #(
  parameter int unsigned LineLenBits = smtp_pkg::LineLenBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config: max_line_len
  input  logic                            cfg_we_i,
  input  logic [smtp_pkg::CfgLenBits-1:0] cfg_wdata_i,
  // slave side
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
  input  logic                            s_axis_tuser,  // [0] action
  // master side
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,  // [9:0] reply_code, [11:10] reply_class
  output logic [2:0]                      m_axis_tuser   // [2:0] status
);
  import smtp_pkg::*;

  logic [CfgLenBits-1:0] max_len_q;

  logic       in_valid_q;
  logic       in_action_q;
  logic [7:0] in_byte_q;

  logic       out_valid_q;
  logic [9:0] out_code_q;
  logic [1:0] out_cls_q;
  logic [2:0] out_status_q;

  result_t res;
  logic    fire;

  // The checked beat leaves the input register unless it makes a result
  // and the result register is still held by the sink.
  assign fire = in_valid_q && (!out_valid_q || m_axis_tready || !res.emit);
  assign s_axis_tready = !in_valid_q || fire;

  smtp_line_unit #(.LineLenBits(LineLenBits)) u_line (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (fire),
    .action_i  (in_action_q),
    .byte_i    (in_byte_q),
    .max_len_i (max_len_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLineLenRst;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_action_q <= s_axis_tuser;
      in_byte_q   <= s_axis_tdata;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && res.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res.emit) begin
      out_code_q   <= res.code;
      out_cls_q    <= res.cls;
      out_status_q <= res.status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_cls_q, out_code_q};
  assign m_axis_tuser  = out_status_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fire && res.emit && out_valid_q && !m_axis_tready))
    else $error("result register overwritten while stalled");
  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q != StDone |-> out_code_q == 10'd0 && out_cls_q == ClsOther)
    else $error("error result with nonzero code or wrong class");
  a_done_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q == StDone |-> out_cls_q == class_of(out_code_q))
    else $error("reply class does not match code");
  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !fire |=> in_valid_q && $stable(in_byte_q) && $stable(in_action_q))
    else $error("pending input beat lost");

endmodule

// ===== rtl/smtp_line_unit.sv =====
// Per-byte line/reply state and checks of the SMTP reply parser.
module smtp_line_unit #(
  parameter int unsigned LineLenBits = smtp_pkg::LineLenBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  logic                                action_i,
  input  logic [7:0]                          byte_i,
  input  logic [smtp_pkg::CfgLenBits-1:0]     max_len_i,
  output smtp_pkg::result_t                   res_o
);
  import smtp_pkg::*;

  localparam int unsigned CmpW = (LineLenBits > CfgLenBits) ? LineLenBits : CfgLenBits;
  localparam logic [CmpW-1:0] Cap = CmpW'((64'd1 << LineLenBits) - 64'd1);

  logic [LineLenBits-1:0] len_q, len_d;
  logic [9:0]             code_q, code_d;
  logic                   dig_q, dig_d;
  logic [1:0]             sep_q, sep_d;
  logic [9:0]             first_q, first_d;
  logic                   have_q, have_d;

  logic [CmpW-1:0] limit, len_ext, max_ext;
  logic [9:0]      code_n;
  logic            dig_n;
  logic [1:0]      sep_n;
  logic            is_digit;

  // CR is not treated specially: it counts as a line byte, and a bare LF and CR LF both end the line.
  always_comb begin
    max_ext  = CmpW'(max_len_i);
    limit    = (max_ext < Cap) ? max_ext : Cap;
    len_ext  = CmpW'(len_q) + CmpW'(1);
    is_digit = byte_i inside {[ChZero:ChNine]};

    code_n = code_q;
    dig_n  = dig_q;
    sep_n  = sep_q;
    if (len_q < LineLenBits'(3)) begin
      if (is_digit) begin
        code_n = (code_q << 3) + (code_q << 1) + {6'd0, byte_i[3:0]};
      end else begin
        dig_n = 1'b0;
      end
    end else if (len_q == LineLenBits'(3)) begin
      if (byte_i == ChSpace)     sep_n = SepSpace;
      else if (byte_i == ChDash) sep_n = SepDash;
      else                       sep_n = SepOther;
    end

    res_o = '{emit: 1'b0, code: 10'd0, cls: ClsOther, status: StDone};
    len_d   = len_q;
    code_d  = code_q;
    dig_d   = dig_q;
    sep_d   = sep_q;
    first_d = first_q;
    have_d  = have_q;

    if (action_i) begin
      res_o.emit   = 1'b1;
      res_o.status = StStreamEnd;
    end else if (byte_i == ChLf && len_ext <= limit) begin
      if (len_ext < CmpW'(4)) begin
        res_o.emit = 1'b1; res_o.status = StShort;
      end else if (!dig_n) begin
        res_o.emit = 1'b1; res_o.status = StBadDigit;
      end else if (sep_n != SepSpace && sep_n != SepDash) begin
        res_o.emit = 1'b1; res_o.status = StBadSep;
      end else if (have_q && code_n != first_q) begin
        res_o.emit = 1'b1; res_o.status = StCodeChg;
      end else if (sep_n == SepSpace) begin
        res_o.emit   = 1'b1;
        res_o.code   = have_q ? first_q : code_n;
        res_o.cls    = class_of(res_o.code);
        res_o.status = StDone;
      end else begin
        // continuation line accepted: start next line, keep first code
        len_d  = '0;
        code_d = 10'd0;
        dig_d  = 1'b1;
        sep_d  = SepNone;
        if (!have_q) begin
          first_d = code_n;
          have_d  = 1'b1;
        end
      end
    end else if (len_ext >= limit) begin
      res_o.emit   = 1'b1;
      res_o.status = StTooLong;
    end else begin
      len_d  = len_ext[LineLenBits-1:0];
      code_d = code_n;
      dig_d  = dig_n;
      sep_d  = sep_n;
    end

    // any result restarts the reply
    if (res_o.emit) begin
      len_d   = '0;
      code_d  = 10'd0;
      dig_d   = 1'b1;
      sep_d   = SepNone;
      first_d = 10'd0;
      have_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      code_q  <= 10'd0;
      dig_q   <= 1'b1;
      sep_q   <= SepNone;
      first_q <= 10'd0;
      have_q  <= 1'b0;
    end else if (step_i) begin
      len_q   <= len_d;
      code_q  <= code_d;
      dig_q   <= dig_d;
      sep_q   <= sep_d;
      first_q <= first_d;
      have_q  <= have_d;
    end
  end

  a_len_below_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(len_q) < Cap) else $error("line length reached counter cap");
  a_first_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_q |-> first_q <= 10'd999) else $error("first code out of range");
  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.emit |=> len_q == '0 && !have_q)
    else $error("reply state not cleared after result");

endmodule
